@@ rtl/core/tzkq_pkg.sv @@
// Shared types and constants for the touch zone key event queue.
// Depends on nothing; every other file in rtl/core but tzkq_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package tzkq_pkg;

   // Ring geometry and field widths
   localparam int RING_DEPTH_DEFAULT = 32;
   localparam int ZONE_COUNT         = 8;
   localparam int ZONE_IDX_W         = 3;
   localparam int COORD_W            = 12;
   localparam int KEY_W              = 8;
   localparam int EVENT_W            = KEY_W + 1;
   localparam int DROP_W             = 4;
   localparam int KEY_MAP_W          = ZONE_COUNT * KEY_W;
   localparam int CSR_ADDR_W         = 4;

   // Pad geometry: pad starts at row 200, zones are 80 wide and 140 tall
   localparam int PAD_TOP   = 200;
   localparam int ZONE_W    = 80;
   localparam int ZONE_H    = (480 - PAD_TOP) / 2;
   localparam int ROW_SPLIT = PAD_TOP + ZONE_H;

   // Request codes
   localparam logic REQ_TOUCH = 1'b0;
   localparam logic REQ_POP   = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [3:0]           touch_count;
      logic [COORD_W-1:0]   first_x;
      logic [COORD_W-1:0]   first_y;
      logic [COORD_W-1:0]   second_x;
      logic [COORD_W-1:0]   second_y;
   } req_payload_type;

   typedef struct packed {
      logic [ZONE_COUNT-1:0] held_mask;
      logic                  event_valid;
      logic                  event_pressed;
      logic [KEY_W-1:0]      event_key;
      logic [DROP_W-1:0]     dropped_events;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_POP_WAIT,
      ST_DONE
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic zone_calc;
      logic scan_step;
      logic pop_read;
      logic result_write;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_is_pop;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/core/touch_zone_key_event_queue.sv @@
// Top level of the touch zone key event queue: key map register and wiring.
// Depends on tzkq_pkg, tzkq_ctrl and tzkq_dp.
`timescale 1ns / 1ps
`default_nettype none

// Turns touch reports into key press/release events held in a ring of
// RING_DEPTH entries (at most RING_DEPTH-1 events stored; pushes to a full
// ring are dropped and counted in the report's result). Every request gives
// exactly one result. One request is in work at a time: a touch report is
// scanned over the eight zones, one zone and at most one ring write per
// cycle; a pop goes through the registered read of the ring memory. A
// finished result waits in an output register and the next request is
// accepted meanwhile. The key map is a 64-bit register at address 0 of the
// APB port; write it only while no request is in work.
module touch_zone_key_event_queue
   import tzkq_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [KEY_MAP_W-1:0]  pwdata,
   output logic [KEY_MAP_W-1:0]       prdata,
   output logic                       pready
);

   logic [KEY_MAP_W-1:0] key_map_ff;
   logic                 key_map_sel;
   dp_cmd_type           cmd;
   dp_status_type        status;

   // Register decode: key map occupies the first 8-byte slot
   assign key_map_sel = (paddr[CSR_ADDR_W-1] == 1'b0);
   assign pready      = 1'b1;
   assign prdata      = key_map_sel ? key_map_ff : '0;

   // Write key map
   always_ff @(posedge clock) begin
      if (reset) begin
         key_map_ff <= '0;
      end else if (psel && penable && pwrite && pready && key_map_sel) begin
         key_map_ff <= pwdata;
      end
   end

   tzkq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tzkq_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .key_map   (key_map_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/core/tzkq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tzkq_ram #(
   parameter  int WIDTH = 9,
   parameter  int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/tzkq_ctrl.sv @@
// Sequencer for the key event queue: accepts a request, steps the datapath.
// Depends on tzkq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tzkq_ctrl
   import tzkq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = status.req_is_pop ? ST_POP_WAIT : ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_POP_WAIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready        = 1'b0;
      cmd              = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DECODE: begin
            cmd.zone_calc = !status.req_is_pop;
            cmd.pop_read  = status.req_is_pop;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_POP_WAIT: begin
            cmd = '0;
         end
         ST_DONE: begin
            cmd.result_write = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/tzkq_dp.sv @@
// Datapath: zone mapping, held mask, event ring pointers and result register.
// Depends on tzkq_pkg and tzkq_ram.
`timescale 1ns / 1ps
`default_nettype none

module tzkq_dp
   import tzkq_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dp_cmd_type           cmd,
   output dp_status_type             status,
   input  wire req_payload_type      req_data,
   input  wire logic [KEY_MAP_W-1:0] key_map,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_payload_type           rsp_data
);

   localparam int PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);

   // Map one point to a one-hot zone bit, zero above the pad
   function automatic logic [ZONE_COUNT-1:0] zone_bit(input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y);
      logic [1:0]            col;
      logic                  row;
      logic [ZONE_COUNT-1:0] bits;
      if (x >= COORD_W'(3 * ZONE_W)) begin
         col = 2'd3;
      end else if (x >= COORD_W'(2 * ZONE_W)) begin
         col = 2'd2;
      end else if (x >= COORD_W'(ZONE_W)) begin
         col = 2'd1;
      end else begin
         col = 2'd0;
      end
      row  = (y >= COORD_W'(ROW_SPLIT));
      bits = ZONE_COUNT'(1) << {col, row};
      if (y < COORD_W'(PAD_TOP)) begin
         bits = '0;
      end
      return bits;
   endfunction

   req_payload_type       req_ff;
   logic [ZONE_COUNT-1:0] held_ff;
   logic [ZONE_COUNT-1:0] changed_ff;
   logic [ZONE_IDX_W-1:0] zone_ff;
   logic [DROP_W-1:0]     drop_ff;
   logic [PtrW-1:0]       wr_ff;
   logic [PtrW-1:0]       rd_ff;
   logic                  ev_valid_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_ff;

   logic [ZONE_COUNT-1:0] mask;
   logic [PtrW-1:0]       wr_next;
   logic [PtrW-1:0]       rd_next;
   logic                  ring_full;
   logic                  ring_empty;
   logic                  zone_changed;
   logic                  push;
   logic                  pop;
   logic [EVENT_W-1:0]    push_event;
   logic [EVENT_W-1:0]    pop_event;

   // New held mask from the captured report
   always_comb begin
      mask = '0;
      if (req_ff.touch_count != 4'd0) begin
         mask = mask | zone_bit(req_ff.first_x, req_ff.first_y);
      end
      if (req_ff.touch_count[3:1] != 3'd0) begin
         mask = mask | zone_bit(req_ff.second_x, req_ff.second_y);
      end
   end

   // Ring pointers and occupancy
   assign wr_next    = (wr_ff == PtrLast) ? '0 : wr_ff + 1'b1;
   assign rd_next    = (rd_ff == PtrLast) ? '0 : rd_ff + 1'b1;
   assign ring_full  = (wr_next == rd_ff);
   assign ring_empty = (wr_ff == rd_ff);

   // One zone per scan step
   assign zone_changed = changed_ff[zone_ff];
   assign push         = cmd.scan_step && zone_changed && !ring_full;
   assign pop          = cmd.pop_read && !ring_empty;
   assign push_event   = {held_ff[zone_ff], key_map[zone_ff * KEY_W +: KEY_W]};

   tzkq_ram #(
      .WIDTH (EVENT_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ff),
      .wr_data (push_event),
      .rd_en   (pop),
      .rd_addr (rd_ff),
      .rd_data (pop_event)
   );

   // Capture request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Held mask, change set, scan counter and drop count
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         changed_ff  <= '0;
         zone_ff     <= '0;
         drop_ff     <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            zone_ff     <= '0;
            drop_ff     <= '0;
            ev_valid_ff <= 1'b0;
         end
         if (cmd.zone_calc) begin
            held_ff    <= mask;
            changed_ff <= mask ^ held_ff;
         end
         if (cmd.scan_step) begin
            zone_ff <= zone_ff + 1'b1;
            if (zone_changed && ring_full) begin
               drop_ff <= drop_ff + 1'b1;
            end
         end
         if (pop) begin
            ev_valid_ff <= 1'b1;
         end
      end
   end

   // Advance ring pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_next;
         end
         if (pop) begin
            rd_ff <= rd_next;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_write) begin
         rsp_ff.held_mask      <= held_ff;
         rsp_ff.event_valid    <= ev_valid_ff;
         rsp_ff.event_pressed  <= ev_valid_ff & pop_event[KEY_W];
         rsp_ff.event_key      <= ev_valid_ff ? pop_event[KEY_W-1:0] : '0;
         rsp_ff.dropped_events <= drop_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status back to the sequencer
   assign status.req_is_pop = (req_ff.req_type == REQ_POP);
   assign status.scan_last  = (zone_ff == ZONE_IDX_W'(ZONE_COUNT - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

@@ sim/tzkq_checker.sv @@
// Checker for the touch zone key event queue: watches the request, result and
// key map write traffic, predicts each result and compares it. Uses tzkq_pkg.
`timescale 1ns / 1ps

module tzkq_checker
   import tzkq_pkg::*;
#(
   parameter int                    RING_DEPTH   = RING_DEPTH_DEFAULT,
   parameter logic [CSR_ADDR_W-1:0] KEY_MAP_ADDR = '0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire req_payload_type       req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire rsp_payload_type       rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [KEY_MAP_W-1:0]  pwdata,
   output int                         mismatch_count,
   output int                         pending_results,
   output int                         events_popped,
   output int                         events_dropped
);

   localparam int LAST_COL = 3;
   localparam int LAST_ROW = 1;

   // Shadow copy of the block's state
   logic [KEY_MAP_W-1:0]  key_map;
   logic [ZONE_COUNT-1:0] held_zones;
   logic [EVENT_W-1:0]    event_ring [RING_DEPTH];
   int unsigned           wr_slot;
   int unsigned           rd_slot;
   rsp_payload_type       expected_results [$];
   int                    fails;
   int                    popped;
   int                    dropped;

   // Map one panel point to its one-hot zone bit; zero above the pad
   function automatic logic [ZONE_COUNT-1:0] zone_of_point(input logic [COORD_W-1:0] x,
                                                           input logic [COORD_W-1:0] y);
      int unsigned col;
      int unsigned row;
      if (y < PAD_TOP) return '0;
      col = x / ZONE_W;
      if (col > LAST_COL) col = LAST_COL;
      row = (y - PAD_TOP) / ZONE_H;
      if (row > LAST_ROW) row = LAST_ROW;
      return ZONE_COUNT'(1) << (col * 2 + row);
   endfunction

   // Advance the shadow state by one request and return its result
   function automatic rsp_payload_type predict_result(input req_payload_type r);
      rsp_payload_type       res;
      logic [ZONE_COUNT-1:0] hit;
      logic [ZONE_COUNT-1:0] changed;
      int unsigned           next_slot;
      res = '0;
      if (r.req_type == REQ_TOUCH) begin
         hit = '0;
         if (r.touch_count >= 1) hit |= zone_of_point(r.first_x, r.first_y);
         if (r.touch_count >= 2) hit |= zone_of_point(r.second_x, r.second_y);
         changed = hit ^ held_zones;
         for (int z = 0; z < ZONE_COUNT; z++) begin
            if (changed[z]) begin
               next_slot = (wr_slot + 1) % RING_DEPTH;
               // drop the event when the ring is full
               if (next_slot == rd_slot) begin
                  res.dropped_events = res.dropped_events + 1'b1;
               end else begin
                  event_ring[wr_slot] = {hit[z], key_map[KEY_W*z +: KEY_W]};
                  wr_slot = next_slot;
               end
            end
         end
         held_zones = hit;
      end else if (rd_slot != wr_slot) begin
         res.event_valid = 1'b1;
         {res.event_pressed, res.event_key} = event_ring[rd_slot];
         rd_slot = (rd_slot + 1) % RING_DEPTH;
      end
      res.held_mask = held_zones;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fails++;
      end
   endtask

   // Track key map writes, compare results, predict accepted requests
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         key_map    = '0;
         held_zones = '0;
         wr_slot    = 0;
         rd_slot    = 0;
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == KEY_MAP_ADDR) key_map = pwdata;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("rsp_data: result 0x%0h with no request waiting", rsp_data);
               fails++;
            end else begin
               want = expected_results.pop_front();
               check_field("held_mask", 16'(want.held_mask),
                           16'(rsp_data.held_mask));
               check_field("event_valid", 16'(want.event_valid),
                           16'(rsp_data.event_valid));
               check_field("event_pressed", 16'(want.event_pressed),
                           16'(rsp_data.event_pressed));
               check_field("event_key", 16'(want.event_key),
                           16'(rsp_data.event_key));
               check_field("dropped_events", 16'(want.dropped_events),
                           16'(rsp_data.dropped_events));
            end
         end
         if (req_valid && req_ready) begin
            want = predict_result(req_data);
            popped  += int'(want.event_valid);
            dropped += int'(want.dropped_events);
            expected_results.push_back(want);
         end
      end
      // publish counts after the edge so readers see a stable value
      mismatch_count  <= fails;
      pending_results <= expected_results.size();
      events_popped   <= popped;
      events_dropped  <= dropped;
   end

endmodule

@@ sim/touch_zone_key_event_queue_test.sv @@
// Testbench top for the touch zone key event queue: clock, reset, request and
// key map stimulus, random result stalls and the verdict. Uses tzkq_pkg and tzkq_checker.
`timescale 1ns / 1ps

module touch_zone_key_event_queue_test;
   import tzkq_pkg::*;

   localparam int                    ITEM_COUNT   = 1900;
   localparam int                    PHASES       = 6;
   localparam int                    CYCLE_LIMIT  = 400000;
   localparam int                    SETTLE       = 24;
   localparam logic [CSR_ADDR_W-1:0] KEY_MAP_ADDR = '0;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [KEY_MAP_W-1:0]  pwdata;
   logic [KEY_MAP_W-1:0]  prdata;
   logic                  pready;

   bit  steady = 1'b0;
   int  mismatch_count;
   int  pending_results;
   int  events_popped;
   int  events_dropped;
   int  touches_sent;
   int  pops_sent;
   int  maps_written;
   int  cycle_count;

   touch_zone_key_event_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   tzkq_checker #(.KEY_MAP_ADDR(KEY_MAP_ADDR)) scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .events_popped   (events_popped),
      .events_dropped  (events_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stall the result side about a quarter of the time, never while steady
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 25);
   end

   // End the run if it hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
   end

   // Hold one request until accepted, then, unless steady, sometimes drop valid
   task automatic send_request(input req_payload_type p);
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      if (p.req_type == REQ_POP) pops_sent++;
      else touches_sent++;
      if (!steady && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Stop sending until every expected result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_key_map(input logic [KEY_MAP_W-1:0] value);
      drain_results();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= KEY_MAP_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      maps_written++;
   endtask

   function automatic req_payload_type touch_report(input int unsigned n,
                                                    input int unsigned x1, input int unsigned y1,
                                                    input int unsigned x2, input int unsigned y2);
      req_payload_type p;
      p.req_type    = REQ_TOUCH;
      p.touch_count = 4'(n);
      p.first_x     = COORD_W'(x1);
      p.first_y     = COORD_W'(y1);
      p.second_x    = COORD_W'(x2);
      p.second_y    = COORD_W'(y2);
      return p;
   endfunction

   // Pop with random don't-care fields
   function automatic req_payload_type pop_request();
      return touch_report(0, 0, 0, 0, 0) | {REQ_POP, 4'($urandom_range(0, 15)),
             12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
             12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095))};
   endfunction

   // Mostly on-screen coordinates, with zone edges and the full range mixed in
   function automatic logic [COORD_W-1:0] pick_coord(input bit is_row);
      case ($urandom_range(0, 9))
         0, 1: return COORD_W'($urandom_range(0, 4095));
         2: begin
            if (is_row) begin
               return COORD_W'(($urandom_range(0, 1) ? ROW_SPLIT : PAD_TOP)
                               - $urandom_range(0, 1));
            end
            return COORD_W'(ZONE_W * $urandom_range(0, 4) - $urandom_range(0, 1));
         end
         default: begin
            return is_row ? COORD_W'($urandom_range(150, 479))
                          : COORD_W'($urandom_range(0, 479));
         end
      endcase
   endfunction

   function automatic req_payload_type random_report();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(0, 99);
      if (pick < 12) n = 0;
      else if (pick < 85) n = $urandom_range(1, 2);
      else n = $urandom_range(3, 15);
      return touch_report(n, pick_coord(1'b0), pick_coord(1'b1),
                          pick_coord(1'b0), pick_coord(1'b1));
   endfunction

   initial begin
      req_payload_type      last_report;
      logic [KEY_MAP_W-1:0] map_value;
      int                   pop_pct;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: distinct key per zone, pad edges, point count cases
      write_key_map(64'hF7E6_D5C4_B3A2_9180);
      send_request(pop_request());                                // empty ring
      send_request(touch_report(0, 0, 0, 0, 0));                  // no points touched
      send_request(touch_report(1, 0, PAD_TOP, 0, 0));            // pad top edge
      send_request(touch_report(1, 0, PAD_TOP - 1, 0, 0));        // above the pad
      send_request(touch_report(2, 79, 339, 4095, 4095));
      send_request(touch_report(2, 80, 340, 239, 479));
      send_request(touch_report(15, 160, 200, 320, 4095));        // extra points ignored
      send_request(touch_report(1, 400, 300, 0, 4095));           // second point unused
      send_request(touch_report(2, 10, 210, 70, 330));            // both in one zone
      send_request(touch_report(15, 4095, 4095, 4095, 4095));
      repeat (3) send_request(pop_request());
      // Overfill the ring: each report after the first flips four zones
      for (int i = 0; i < 9; i++) begin
         if (i % 2 == 0) send_request(touch_report(2, 0, 200, 4095, 4095));
         else send_request(touch_report(2, 80, 340, 160, 200));
      end

      // Random phases, each under its own key map and pop rate
      last_report = touch_report(0, 0, 0, 0, 0);
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: map_value = '1;
            1: map_value = '0;
            default: map_value = {$urandom, $urandom};
         endcase
         write_key_map(map_value);
         steady <= (phase == 2);
         case (phase)
            1: pop_pct = 70;
            3: pop_pct = 20;
            default: pop_pct = $urandom_range(35, 55);
         endcase
         for (int i = 0; i < ITEM_COUNT / PHASES; i++) begin
            if ($urandom_range(0, 99) < pop_pct) begin
               send_request(pop_request());
            end else begin
               // repeat the last report now and then: no zone changes
               if ($urandom_range(0, 99) >= 15) last_report = random_report();
               send_request(last_report);
            end
         end
      end

      // Wait out the last results, then report
      drain_results();
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d touch reports and %0d pops under %0d key maps.",
               touches_sent, pops_sent, maps_written);
      $display("%0d events came out of the ring and %0d were dropped on a full ring.",
               events_popped, events_dropped);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
